// ===== rtl/core/sopll_pkg.sv =====
package sopll_pkg;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_START_PHASE = 3'd3;

  localparam logic signed [31:0] COEF_B0_RST     = 32'sd30794918;
  localparam logic signed [31:0] COEF_B1_RST     = 32'sd858993;
  localparam logic signed [31:0] COEF_B2_RST     = -32'sd29935925;
  localparam logic signed [15:0] START_PHASE_RST = 16'sd31291;

  // integrator and product split
  localparam int unsigned INT_W    = 40;
  localparam int unsigned LO_BITS  = 20;
  localparam int unsigned ACC_W    = 46;
  localparam logic [2:0]  MAC_LAST = 3'd6;

  // CORDIC arctangent table, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic start;
    logic rot_mode;
  } cordic_ctrl_t;

endpackage

// ===== rtl/core/sopll_if.sv =====
interface sopll_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_i;
  logic signed [15:0] in_q;
  modport source (output valid, output in_i, output in_q, input ready);
  modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

interface sopll_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] osc_i;
  logic signed [15:0] osc_q;
  logic signed [15:0] phase_err;
  logic signed [15:0] next_phase;
  logic               sat_flag;
  modport source (output valid, output osc_i, output osc_q, output phase_err,
                  output next_phase, output sat_flag, input ready);
  modport sink   (input valid, input osc_i, input osc_q, input phase_err,
                  input next_phase, input sat_flag, output ready);
endinterface

// ===== rtl/core/sopll_cordic.sv =====
module sopll_cordic import sopll_pkg::*; #(
  parameter int STAGES = 16,
  parameter int CW     = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_ctrl_t         ctrl,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic [31:0]          z0,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic [31:0]          z,
  output logic                 done
);
  localparam int CNT_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STAGES - 1);

  logic             run;
  logic             rot_mode;
  logic [CNT_W-1:0] cnt;
  logic signed [CW-1:0] xs, ys;
  logic [31:0]      ang;
  logic             sigma;

  assign xs    = x >>> cnt;
  assign ys    = y >>> cnt;
  assign ang   = ATAN_TAB[5'(cnt)];
  // rotation drives z to zero, vectoring drives y to zero
  assign sigma = rot_mode ? !z[31] : !(y > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        run      <= 1'b1;
        cnt      <= '0;
        rot_mode <= ctrl.rot_mode;
        x        <= x0;
        y        <= y0;
        z        <= z0;
      end else if (run) begin
        if (sigma) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ang;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ang;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/sopll_mac.sv =====
module sopll_mac import sopll_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [31:0]      b0,
  input  logic signed [31:0]      b1,
  input  logic signed [31:0]      b2,
  input  logic signed [INT_W-1:0] w0,
  input  logic signed [INT_W-1:0] w1,
  input  logic signed [INT_W-1:0] w2,
  output logic [31:0]             inc,
  output logic                    done
);
  logic              run;
  logic [2:0]        cnt;
  logic signed [31:0]      coef;
  logic signed [INT_W-1:0] wsel;
  logic signed [LO_BITS:0] op;
  logic signed [52:0]      prod;
  logic                    prod_hi;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        addend;

  // step: term = cnt / 2, odd steps take the high half of w
  always_comb begin
    unique case (cnt[2:1])
      2'd0:    begin coef = b0; wsel = w0; end
      2'd1:    begin coef = b1; wsel = w1; end
      default: begin coef = b2; wsel = w2; end
    endcase
    op = cnt[0] ? $signed({wsel[INT_W-1], wsel[INT_W-1:LO_BITS]}) :
                  $signed({1'b0, wsel[LO_BITS-1:0]});
    addend = prod_hi ? {prod[ACC_W-LO_BITS-1:0], {LO_BITS{1'b0}}} : prod[ACC_W-1:0];
  end

  assign inc = acc[45:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        acc <= '0;
      end else if (run) begin
        prod    <= coef * op;
        prod_hi <= cnt[0];
        if (cnt != 3'd0) acc <= acc + addend;
        cnt <= cnt + 1'b1;
        if (cnt == MAC_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/second_order_phase_locked_loop.sv =====
// Channel  | Dir | Payload                                         | Transaction
// ---------+-----+-------------------------------------------------+-------------------
// in_ch    | in  | in_i, in_q                                      | valid & ready
// out_ch   | out | osc_i, osc_q, phase_err, next_phase, sat_flag   | valid & ready
// cfg      | in  | cfg_addr, cfg_data                              | cfg_en
//
// One shared CORDIC iteration unit runs rotation, then vectoring, then a 7-step
// multiply accumulate forms the loop filter increment. The result becomes valid
// after states ST_ROT, ST_VEC, ST_MAC and ST_FIN; a new transaction is taken only
// after the last one has reached the output register. in_ch.ready is high
// only when idle. The result sits in an output register; a new sample is taken while
// it waits, and the next result stalls until it has been taken.
// Reset (rst, synchronous) restores coefficients and clears the loop state.
module second_order_phase_locked_loop import sopll_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_data,
  sopll_in_if.sink              in_ch,
  sopll_out_if.source           out_ch
);
  localparam int SB = SAMPLE_BITS;
  localparam int CW = (SB + 11 > 34) ? SB + 11 : 34;
  localparam logic signed [CW-1:0] ROT_X0 = CW'(652032874);  // 1/K in Q1.30

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROT  = 3'd1;
  localparam logic [2:0] ST_VEC  = 3'd2;
  localparam logic [2:0] ST_MAC  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // config
  logic signed [31:0] coef_b0, coef_b1, coef_b2;
  logic signed [15:0] start_phase;

  // loop state
  logic signed [INT_W-1:0] err_integrator, err_integrator_prev, err_integrator_prev2;
  logic [31:0]             phase_accumulator;
  logic                    first_item;

  logic [2:0]  state;
  logic [15:0] ph16, ph16_next;
  logic        flip;
  logic        zero_in;
  logic signed [SB-1:0] si, sq, si_r, sq_r;

  // per-item results held until the output register is free
  logic signed [15:0] osc_i_r, osc_q_r, err_r;
  logic               sat_r;

  cordic_ctrl_t         cctl;
  logic signed [CW-1:0] cx0, cy0, cx, cy;
  logic [31:0]          cz0, cz;
  logic                 cdone;
  logic                 mac_start, mac_done;
  logic [31:0]          inc;

  logic in_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  // input: low SAMPLE_BITS bits sign-extended when SAMPLE_BITS <= 16, else zero-extended
  generate
    if (SB <= 16) begin : g_sext
      assign si = $signed(in_ch.in_i[SB-1:0]);
      assign sq = $signed(in_ch.in_q[SB-1:0]);
    end else begin : g_zext
      assign si = $signed({{(SB-16){1'b0}}, in_ch.in_i});
      assign sq = $signed({{(SB-16){1'b0}}, in_ch.in_q});
    end
  endgenerate

  assign ph16_next = first_item ? start_phase : phase_accumulator[31:16];

  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767))       to_q15 = 16'sd32767;
    else if (r < -CW'(32767)) to_q15 = -16'sd32767;
    else                      to_q15 = r[15:0];
  endfunction

  // CORDIC operand setup
  logic [31:0]          rz;
  logic                 rflip;
  logic signed [CW-1:0] vx, vy;
  always_comb begin
    rz    = {ph16_next, 16'h0000};
    rflip = ($signed(rz) > 32'sh40000000) || ($signed(rz) < -32'sh40000000);
    if (rflip) rz[31] = ~rz[31];  // +-half turn
    vx = CW'(si_r) <<< 8;
    vy = CW'(sq_r) <<< 8;
    cctl = '{start: 1'b0, rot_mode: 1'b1};
    cx0  = ROT_X0;
    cy0  = '0;
    cz0  = rz;
    if (state == ST_ROT) begin
      cctl.rot_mode = 1'b0;
      if (vx < 0) begin
        cx0 = -vx;
        cy0 = -vy;
        cz0 = 32'h80000000;
      end else begin
        cx0 = vx;
        cy0 = vy;
        cz0 = 32'h0;
      end
    end
    cctl.start = in_fire || (state == ST_ROT && cdone);
  end

  sopll_cordic #(.STAGES(CORDIC_STAGES), .CW(CW)) u_cordic (
    .clk(clk), .rst(rst), .ctrl(cctl),
    .x0(cx0), .y0(cy0), .z0(cz0),
    .x(cx), .y(cy), .z(cz), .done(cdone)
  );

  // error, integrator with saturation
  logic [31:0]          diff, diff_rnd;
  logic signed [15:0]   err;
  logic signed [INT_W:0] wsum;
  logic signed [INT_W-1:0] w_sat;
  logic                 sat;
  always_comb begin
    diff     = (zero_in ? 32'h0 : cz) - {ph16, 16'h0000};
    diff_rnd = diff + 32'h00008000;
    err      = $signed(diff_rnd[31:16]);
    wsum     = $signed({err_integrator[INT_W-1], err_integrator}) + (INT_W+1)'(err);
    sat      = wsum[INT_W] != wsum[INT_W-1];
    if (!sat)               w_sat = wsum[INT_W-1:0];
    else if (wsum[INT_W])   w_sat = {1'b1, {(INT_W-1){1'b0}}};
    else                    w_sat = {1'b0, {(INT_W-1){1'b1}}};
  end

  assign mac_start = (state == ST_VEC) && cdone;

  sopll_mac u_mac (
    .clk(clk), .rst(rst), .start(mac_start),
    .b0(coef_b0), .b1(coef_b1), .b2(coef_b2),
    .w0(err_integrator), .w1(err_integrator_prev), .w2(err_integrator_prev2),
    .inc(inc), .done(mac_done)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0     <= COEF_B0_RST;
      coef_b1     <= COEF_B1_RST;
      coef_b2     <= COEF_B2_RST;
      start_phase <= START_PHASE_RST;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_COEF_B0:     coef_b0     <= cfg_data;
        REG_COEF_B1:     coef_b1     <= cfg_data;
        REG_COEF_B2:     coef_b2     <= cfg_data;
        REG_START_PHASE: start_phase <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      err_integrator       <= '0;
      err_integrator_prev  <= '0;
      err_integrator_prev2 <= '0;
      phase_accumulator    <= '0;
      first_item           <= 1'b1;
      out_ch.valid         <= 1'b0;
    end else begin
      // ST_FIN reloads valid itself
      if (out_ch.valid && out_ch.ready && state != ST_FIN) out_ch.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            si_r    <= si;
            sq_r    <= sq;
            zero_in <= (si == '0) && (sq == '0);
            ph16    <= ph16_next;
            flip    <= rflip;
            state   <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (cdone) begin
            osc_i_r <= to_q15(flip ? -cx : cx);
            osc_q_r <= to_q15(flip ? -cy : cy);
            state   <= ST_VEC;
          end
        end
        ST_VEC: begin
          if (cdone) begin
            err_r                <= err;
            sat_r                <= sat;
            err_integrator_prev2 <= err_integrator_prev;
            err_integrator_prev  <= err_integrator;
            err_integrator       <= w_sat;
            state                <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            phase_accumulator <= phase_accumulator + inc;
            first_item        <= 1'b0;
            state             <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid      <= 1'b1;
            out_ch.osc_i      <= osc_i_r;
            out_ch.osc_q      <= osc_q_r;
            out_ch.phase_err  <= err_r;
            out_ch.next_phase <= phase_accumulator[31:16];
            out_ch.sat_flag   <= sat_r;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/sopll_checker.sv =====
module sopll_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] osc_i,
  input logic [15:0] osc_q,
  input logic [15:0] phase_err,
  input logic [15:0] next_phase,
  input logic        sat_flag
);
  // a taken sample keeps the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // a new result needs a sample taken first
  a_no_result_without_sample: assert property (@(posedge clk) disable iff (rst)
    !out_valid && $past(in_ready) && in_ready |=> !out_valid)
    else $error("result without a sample");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(osc_i) && $stable(osc_q)
      && $stable(phase_err) && $stable(next_phase) && $stable(sat_flag))
    else $error("stalled result changed");

  // oscillator outputs are clamped to +-32767
  a_osc_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (osc_i != 16'h8000) && (osc_q != 16'h8000))
    else $error("oscillator output out of range");
endmodule

bind second_order_phase_locked_loop sopll_checker u_sopll_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .osc_i(out_ch.osc_i), .osc_q(out_ch.osc_q), .phase_err(out_ch.phase_err),
  .next_phase(out_ch.next_phase), .sat_flag(out_ch.sat_flag)
);
